// ===== sv/sdp_pkg.sv =====
// Shared types, codes and the micro-program for the drying PDE rate block.
// Depends on nothing; every other file imports it.
`default_nettype none
package sdp_pkg;

	localparam int SDP_MAX_NODES = 4096;
	localparam int SDP_FRAC_BITS = 16;

	// operand width inside the sequencer: holds the exact wide numerators
	localparam int OPW       = 36;
	localparam int CFG_IDX_W = 2;
	localparam int PC_W      = 6;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSIVITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK      = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FAULT = 2'd1;
	localparam logic [1:0] STAT_SHORT = 2'd2;

	typedef struct packed {
		logic signed [31:0] moisture;
		logic signed [31:0] radius;
		logic signed [31:0] coordinate;
		logic               last_in;
	} item_t;

	typedef struct packed {
		logic signed [31:0] moisture_rate;
		logic signed [31:0] radius_rate;
		logic [1:0]         status;
		logic               last_out;
	} result_t;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MID, OP_X4, OP_ONEP, OP_MUL, OP_DIV,
		OP_WSUB, OP_WADD, OP_WA3, OP_EMIT, OP_CHK, OP_END
	} op_t;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_X0, SRC_X1, SRC_Z0, SRC_Z1, SRC_PR, SRC_XI, SRC_ZI,
		SRC_RI, SRC_H, SRC_D, SRC_A, SRC_T0, SRC_T1, SRC_T2
	} src_t;

	localparam int SRC_N = 15;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		src_t dst;
		logic last;
	} instr_t;

	typedef struct packed {
		logic                  start;
		op_t                   op;
		logic signed [OPW-1:0] a;
		logic signed [OPW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic                  done;
		logic                  sat;
		logic signed [OPW-1:0] res;
	} alu_rsp_t;

	typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_DIV, AS_FIN} alu_st_t;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_SHORT} ctl_st_t;

	localparam logic [PC_W-1:0] PC_BULK   = 6'd0;
	localparam logic [PC_W-1:0] PC_CENTER = 6'd47;

	function automatic instr_t mk(op_t op, src_t a, src_t b, src_t d, logic l);
		instr_t i;
		i.op   = op;
		i.a    = a;
		i.b    = b;
		i.dst  = d;
		i.last = l;
		return i;
	endfunction

	// bulk node, then the surface tail, then the centre node
	function automatic instr_t sdp_prog(logic [PC_W-1:0] pc);
		instr_t i;
		case (pc)
			6'd0:  i = mk(OP_MID,  SRC_XI, SRC_X1,   SRC_T0, 1'b0);
			6'd1:  i = mk(OP_MUL,  SRC_A,  SRC_T0,   SRC_T1, 1'b0);
			6'd2:  i = mk(OP_ONEP, SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd3:  i = mk(OP_DIV,  SRC_D,  SRC_T1,   SRC_T1, 1'b0);
			6'd4:  i = mk(OP_MID,  SRC_ZI, SRC_Z1,   SRC_T0, 1'b0);
			6'd5:  i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd6:  i = mk(OP_SUB,  SRC_XI, SRC_X1,   SRC_T0, 1'b0);
			6'd7:  i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd8:  i = mk(OP_DIV,  SRC_T1, SRC_H,    SRC_T2, 1'b0);
			6'd9:  i = mk(OP_MID,  SRC_X1, SRC_X0,   SRC_T0, 1'b0);
			6'd10: i = mk(OP_MUL,  SRC_A,  SRC_T0,   SRC_T1, 1'b0);
			6'd11: i = mk(OP_ONEP, SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd12: i = mk(OP_DIV,  SRC_D,  SRC_T1,   SRC_T1, 1'b0);
			6'd13: i = mk(OP_MID,  SRC_Z1, SRC_Z0,   SRC_T0, 1'b0);
			6'd14: i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd15: i = mk(OP_SUB,  SRC_X1, SRC_X0,   SRC_T0, 1'b0);
			6'd16: i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd17: i = mk(OP_DIV,  SRC_T1, SRC_H,    SRC_T1, 1'b0);
			6'd18: i = mk(OP_SUB,  SRC_T2, SRC_T1,   SRC_T2, 1'b0);
			6'd19: i = mk(OP_DIV,  SRC_T2, SRC_H,    SRC_T2, 1'b0);
			6'd20: i = mk(OP_DIV,  SRC_T2, SRC_Z1,   SRC_T2, 1'b0);
			6'd21: i = mk(OP_WSUB, SRC_XI, SRC_X0,   SRC_T0, 1'b0);
			6'd22: i = mk(OP_WADD, SRC_H,  SRC_H,    SRC_T1, 1'b0);
			6'd23: i = mk(OP_DIV,  SRC_T0, SRC_T1,   SRC_T0, 1'b0);
			6'd24: i = mk(OP_MUL,  SRC_A,  SRC_X1,   SRC_T1, 1'b0);
			6'd25: i = mk(OP_ONEP, SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd26: i = mk(OP_DIV,  SRC_D,  SRC_T1,   SRC_T1, 1'b0);
			6'd27: i = mk(OP_MUL,  SRC_A,  SRC_T1,   SRC_T1, 1'b0);
			6'd28: i = mk(OP_MUL,  SRC_T1, SRC_Z1,   SRC_T1, 1'b0);
			6'd29: i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd30: i = mk(OP_DIV,  SRC_T1, SRC_PR,   SRC_T1, 1'b0);
			6'd31: i = mk(OP_EMIT, SRC_T2, SRC_T1,   SRC_T0, 1'b0);
			6'd32: i = mk(OP_CHK,  SRC_ZERO, SRC_ZERO, SRC_T0, 1'b0);
			6'd33: i = mk(OP_WSUB, SRC_X0, SRC_X1,   SRC_T0, 1'b0);
			6'd34: i = mk(OP_WSUB, SRC_XI, SRC_X1,   SRC_T1, 1'b0);
			6'd35: i = mk(OP_WA3,  SRC_T0, SRC_T1,   SRC_T0, 1'b0);
			6'd36: i = mk(OP_WADD, SRC_H,  SRC_H,    SRC_T1, 1'b0);
			6'd37: i = mk(OP_DIV,  SRC_T0, SRC_T1,   SRC_T0, 1'b0);
			6'd38: i = mk(OP_MUL,  SRC_A,  SRC_XI,   SRC_T1, 1'b0);
			6'd39: i = mk(OP_ONEP, SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd40: i = mk(OP_DIV,  SRC_D,  SRC_T1,   SRC_T1, 1'b0);
			6'd41: i = mk(OP_MUL,  SRC_A,  SRC_T1,   SRC_T1, 1'b0);
			6'd42: i = mk(OP_MUL,  SRC_T1, SRC_ZI,   SRC_T1, 1'b0);
			6'd43: i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd44: i = mk(OP_DIV,  SRC_T1, SRC_RI,   SRC_T1, 1'b0);
			6'd45: i = mk(OP_EMIT, SRC_ZERO, SRC_T1, SRC_T0, 1'b1);
			6'd46: i = mk(OP_END,  SRC_ZERO, SRC_ZERO, SRC_T0, 1'b0);
			6'd47: i = mk(OP_MUL,  SRC_A,  SRC_X1,   SRC_T1, 1'b0);
			6'd48: i = mk(OP_ONEP, SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd49: i = mk(OP_DIV,  SRC_D,  SRC_T1,   SRC_T1, 1'b0);
			6'd50: i = mk(OP_SUB,  SRC_XI, SRC_X1,   SRC_T0, 1'b0);
			6'd51: i = mk(OP_MUL,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd52: i = mk(OP_X4,   SRC_T1, SRC_ZERO, SRC_T1, 1'b0);
			6'd53: i = mk(OP_MUL,  SRC_H,  SRC_H,    SRC_T0, 1'b0);
			6'd54: i = mk(OP_DIV,  SRC_T1, SRC_T0,   SRC_T1, 1'b0);
			6'd55: i = mk(OP_EMIT, SRC_T1, SRC_ZERO, SRC_T0, 1'b0);
			default: i = mk(OP_END, SRC_ZERO, SRC_ZERO, SRC_T0, 1'b0);
		endcase
		return i;
	endfunction

endpackage
`default_nettype wire

// ===== sv/sdp_alu.sv =====
// Shared fixed-point unit: saturating add/sub/mid, wide add/sub, multiply,
// bit-serial rounding divider. Depends on sdp_pkg.
`default_nettype none
module sdp_alu import sdp_pkg::*; #(
	parameter int FRAC_BITS = SDP_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int DVW = OPW + FRAC_BITS + 1;
	localparam int DCW = $clog2(DVW + 1);
	localparam int DSW = 33;
	localparam int QW  = 72;

	function automatic logic [32:0] apply_sign(logic [QW-1:0] q, logic neg);
		logic ovf;
		logic [31:0] v;
		if (!neg) begin
			ovf = |q[QW-1:31];
			v   = ovf ? 32'h7fff_ffff : q[31:0];
		end else begin
			ovf = (|q[QW-1:32]) || (q[31] && (|q[30:0]));
			v   = ovf ? 32'h8000_0000 : (32'd0 - q[31:0]);
		end
		return {ovf, v};
	endfunction

	function automatic logic [32:0] sat_s(logic [OPW+1:0] v);
		logic hi;
		logic lo;
		hi = !v[OPW+1] && (|v[OPW:31]);
		lo = v[OPW+1] && !(&v[OPW:31]);
		if (hi) return {1'b1, 32'h7fff_ffff};
		if (lo) return {1'b1, 32'h8000_0000};
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [OPW-1:0] ext32(logic [31:0] v);
		return {{(OPW-32){v[31]}}, v};
	endfunction

	alu_st_t st_q, st_d;

	logic [OPW-1:0]   a_mag, b_mag;
	logic [OPW+1:0]   ea, eb, s_sum, s_mag;
	logic [OPW+1:0]   one_fx;
	logic [32:0]      sr;
	logic             simple_sat;
	logic [OPW-1:0]   simple_res;
	logic [63:0]      prod_q;
	logic [63:0]      prod_rnd;
	logic             neg_q;
	logic [DVW-1:0]   dvd_q;
	logic [DVW-1:0]   quo_q;
	logic [DSW:0]     rem_q;
	logic [DSW:0]     rem_sh;
	logic [DSW-1:0]   mb_q;
	logic [DCW-1:0]   cnt_q;
	logic             done_q, sat_q;
	logic [OPW-1:0]   res_q;
	logic [32:0]      fin_mul, fin_div;

	assign a_mag  = req.a[OPW-1] ? (OPW'(0) - req.a) : req.a;
	assign b_mag  = req.b[OPW-1] ? (OPW'(0) - req.b) : req.b;
	assign ea     = {{2{req.a[OPW-1]}}, req.a};
	assign eb     = {{2{req.b[OPW-1]}}, req.b};
	assign one_fx = (OPW+2)'(1) << FRAC_BITS;
	assign s_sum  = ea + eb;
	assign s_mag  = s_sum[OPW+1] ? ((OPW+2)'(0) - s_sum) : s_sum;

	always_comb begin
		sr         = '0;
		simple_sat = 1'b0;
		simple_res = '0;
		case (req.op)
			OP_ADD:  sr = sat_s(s_sum);
			OP_SUB:  sr = sat_s(ea - eb);
			OP_X4:   sr = sat_s(ea <<< 2);
			OP_ONEP: sr = sat_s(ea + one_fx);
			OP_MID:  sr = apply_sign(QW'((s_mag + (OPW+2)'(1)) >> 1), s_sum[OPW+1]);
			default: sr = '0;
		endcase
		case (req.op)
			OP_WSUB: simple_res = req.a - req.b;
			OP_WADD: simple_res = req.a + req.b;
			OP_WA3:  simple_res = req.a + (req.b <<< 1) + req.b;
			default: begin
				simple_res = ext32(sr[31:0]);
				simple_sat = sr[32];
			end
		endcase
	end

	assign prod_rnd = prod_q + (64'd1 << (FRAC_BITS - 1));
	assign fin_mul  = apply_sign(QW'(prod_rnd >> FRAC_BITS), neg_q);
	assign fin_div  = apply_sign(QW'(quo_q), neg_q);
	assign rem_sh   = {rem_q[DSW-1:0], dvd_q[DVW-1]};

	always_comb begin
		st_d = st_q;
		case (st_q)
			AS_IDLE: begin
				if (req.start && req.op == OP_MUL) st_d = AS_MUL;
				else if (req.start && req.op == OP_DIV && req.b != '0) st_d = AS_DIV;
			end
			AS_MUL: st_d = AS_IDLE;
			AS_DIV: if (cnt_q == DCW'(1)) st_d = AS_FIN;
			AS_FIN: st_d = AS_IDLE;
			default: st_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= AS_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == AS_IDLE && req.start && req.op != OP_MUL &&
				!(req.op == OP_DIV && req.b != '0)) || st_q == AS_MUL || st_q == AS_FIN;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			AS_IDLE: begin
				neg_q  <= req.a[OPW-1] ^ req.b[OPW-1];
				prod_q <= 64'(a_mag[31:0]) * 64'(b_mag[31:0]);
				dvd_q  <= {1'b0, a_mag, {FRAC_BITS{1'b0}}} + DVW'(b_mag[DSW-1:0] >> 1);
				mb_q   <= b_mag[DSW-1:0];
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= DCW'(DVW);
				if (req.op == OP_DIV) begin
					sat_q <= 1'b1;
					if (req.a[OPW-1])      res_q <= ext32(32'h8000_0000);
					else if (req.a != '0)  res_q <= ext32(32'h7fff_ffff);
					else                   res_q <= '0;
				end else begin
					sat_q <= simple_sat;
					res_q <= simple_res;
				end
			end
			AS_MUL: begin
				res_q <= ext32(fin_mul[31:0]);
				sat_q <= fin_mul[32];
			end
			AS_DIV: begin
				if (rem_sh >= {1'b0, mb_q}) begin
					rem_q <= rem_sh - {1'b0, mb_q};
					quo_q <= {quo_q[DVW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DVW-2:0], 1'b0};
				end
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - DCW'(1);
			end
			AS_FIN: begin
				res_q <= ext32(fin_div[31:0]);
				sat_q <= fin_div[32];
			end
			default: res_q <= res_q;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

// ===== sv/shrinking_drying_pde_rate_top.sv =====
// Top level of the drying PDE rate block: sequencer, node window, output register.
// Depends on sdp_pkg and sdp_alu.
//
// Use: nodes of one grid arrive centre first on the item channel (valid/stall).
// A transfer is taken only while the sequencer is idle; item_stall is high for
// the whole computation of a node. Results leave on the result channel one node
// behind: the first node of a grid gives none, the surface node (last_in) gives
// two, the bulk one and then the surface one with last_out set. A last_in on the
// first or second node gives a single result with status "too short".
// Work per node, all on the one shared unit run by a micro-program:
//   a divide produces one quotient bit a cycle.
//   Centre node: 2 divides + 3 multiplies + 3 simple ops.
//   Bulk node: 9 divides + 10 multiplies + 12 simple ops.
//   Surface node: bulk plus 3 divides, 4 multiplies, 5 simple ops more.
// The bit-serial divider dominates the computation of a node. A first node
// only enters the window and starts no computation.
// The output register holds one result; a stalled receiver holds it, and the
// sequencer waits at an emit step until the slot frees.
// Reset: registers go to h = 1.0, D = 1.0, alpha = 0; window and node count clear.
// Configuration writes go through cfg_wen/cfg_index/cfg_data; the user must write only while idle (not enforced).
`default_nettype none
module shrinking_drying_pde_rate_top import sdp_pkg::*; #(
	parameter int MAX_NODES = SDP_MAX_NODES,
	parameter int FRAC_BITS = SDP_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	localparam int CNT_W = $clog2(MAX_NODES);

	// configuration registers
	logic [30:0]        h_q, d_q;
	logic signed [31:0] a_q;

	// node window and latched input
	logic signed [31:0] x0_q, x1_q, z0_q, z1_q, pr_q;
	logic signed [31:0] xi_q, zi_q, ri_q;
	logic               last_q;
	logic [CNT_W-1:0]   cnt_q;

	// sequencer
	ctl_st_t          state_q, state_d;
	logic [PC_W-1:0]  pc_q, start_pc;
	instr_t           instr;
	logic             accept, pc_inc, alu_start, emit, emit_short, finish, shift_now;
	logic             out_free, flag_q;
	logic [OPW-1:0]   t0_q, t1_q, t2_q;
	logic [OPW-1:0]   src_bus [SRC_N];
	logic [OPW-1:0]   opa, opb;
	alu_req_t         req;
	alu_rsp_t         rsp;

	result_t res_q;
	logic    res_valid_q;

	assign instr      = sdp_prog(pc_q);
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign out_free   = !res_valid_q || !result_stall;

	// operand sources for the shared unit
	always_comb begin
		src_bus[SRC_ZERO] = '0;
		src_bus[SRC_X0]   = {{(OPW-32){x0_q[31]}}, x0_q};
		src_bus[SRC_X1]   = {{(OPW-32){x1_q[31]}}, x1_q};
		src_bus[SRC_Z0]   = {{(OPW-32){z0_q[31]}}, z0_q};
		src_bus[SRC_Z1]   = {{(OPW-32){z1_q[31]}}, z1_q};
		src_bus[SRC_PR]   = {{(OPW-32){pr_q[31]}}, pr_q};
		src_bus[SRC_XI]   = {{(OPW-32){xi_q[31]}}, xi_q};
		src_bus[SRC_ZI]   = {{(OPW-32){zi_q[31]}}, zi_q};
		src_bus[SRC_RI]   = {{(OPW-32){ri_q[31]}}, ri_q};
		src_bus[SRC_H]    = {{(OPW-31){1'b0}}, h_q};
		src_bus[SRC_D]    = {{(OPW-31){1'b0}}, d_q};
		src_bus[SRC_A]    = {{(OPW-32){a_q[31]}}, a_q};
		src_bus[SRC_T0]   = t0_q;
		src_bus[SRC_T1]   = t1_q;
		src_bus[SRC_T2]   = t2_q;
	end

	assign opa = src_bus[instr.a];
	assign opb = src_bus[instr.b];

	assign req.start = alu_start;
	assign req.op    = instr.op;
	assign req.a     = opa;
	assign req.b     = opb;

	sdp_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// next state and step strobes
	always_comb begin
		state_d    = state_q;
		start_pc   = PC_BULK;
		pc_inc     = 1'b0;
		alu_start  = 1'b0;
		emit       = 1'b0;
		emit_short = 1'b0;
		finish     = 1'b0;
		shift_now  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.last_in) begin
						if (cnt_q < CNT_W'(2)) state_d = ST_SHORT;
						else state_d = ST_RUN;
					end else if (cnt_q == '0) begin
						// first node of a grid: only enters the window
						shift_now = 1'b1;
					end else begin
						state_d = ST_RUN;
						if (cnt_q == CNT_W'(1)) start_pc = PC_CENTER;
					end
				end
			end
			ST_RUN: begin
				case (instr.op)
					OP_EMIT: begin
						if (out_free) begin
							emit   = 1'b1;
							pc_inc = 1'b1;
						end
					end
					OP_CHK: begin
						if (last_q) pc_inc = 1'b1;
						else begin
							finish  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					OP_END: begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
					default: begin
						alu_start = 1'b1;
						state_d   = ST_WAIT;
					end
				endcase
			end
			ST_WAIT: begin
				if (rsp.done) begin
					pc_inc  = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_SHORT: begin
				if (out_free) begin
					emit_short = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			res_valid_q <= 1'b0;
			h_q         <= 31'd65536;
			d_q         <= 31'd65536;
			a_q         <= '0;
			x0_q        <= '0;
			x1_q        <= '0;
			z0_q        <= '0;
			z1_q        <= '0;
			pr_q        <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_wen) begin
				case (cfg_index)
					REG_GRID_STEP:   h_q <= cfg_data[30:0];
					REG_DIFFUSIVITY: d_q <= cfg_data[30:0];
					REG_SHRINK:      a_q <= cfg_data;
					default:         h_q <= h_q;
				endcase
			end

			if (accept) pc_q <= start_pc;
			else if (pc_inc) pc_q <= pc_q + PC_W'(1);

			// count nodes of the grid; hold at the top, drop to zero on the surface
			if (accept) begin
				if (item.last_in) cnt_q <= '0;
				else if (cnt_q != CNT_W'(MAX_NODES - 1)) cnt_q <= cnt_q + CNT_W'(1);
			end

			if (accept || emit) flag_q <= 1'b0;
			else if (state_q == ST_WAIT && rsp.done) flag_q <= flag_q | rsp.sat;

			// slide the window
			if (shift_now) begin
				x0_q <= x1_q;
				x1_q <= item.moisture;
				z0_q <= z1_q;
				z1_q <= item.coordinate;
				pr_q <= item.radius;
			end else if (finish) begin
				x0_q <= x1_q;
				x1_q <= xi_q;
				z0_q <= z1_q;
				z1_q <= zi_q;
				pr_q <= ri_q;
			end

			if (emit || emit_short) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xi_q   <= item.moisture;
			zi_q   <= item.coordinate;
			ri_q   <= item.radius;
			last_q <= item.last_in;
		end
		if (state_q == ST_WAIT && rsp.done) begin
			case (instr.dst)
				SRC_T0:  t0_q <= rsp.res;
				SRC_T1:  t1_q <= rsp.res;
				SRC_T2:  t2_q <= rsp.res;
				default: t0_q <= t0_q;
			endcase
		end
		if (emit) begin
			res_q.moisture_rate <= opa[31:0];
			res_q.radius_rate   <= opb[31:0];
			res_q.status        <= flag_q ? STAT_FAULT : STAT_OK;
			res_q.last_out      <= instr.last;
		end else if (emit_short) begin
			res_q.moisture_rate <= '0;
			res_q.radius_rate   <= '0;
			res_q.status        <= STAT_SHORT;
			res_q.last_out      <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

// ===== sv/sdp_checker.sv =====
// Port-level checks for the drying PDE rate block, bound to the top level.
// Depends on sdp_pkg.
`default_nettype none
module sdp_checker import sdp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled node holds until its transfer
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("node changed while stalled");

	// a stalled result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a too-short grid closes it with zero rates
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STAT_SHORT |->
			result.last_out && result.moisture_rate == 0 && result.radius_rate == 0)
		else $error("short-grid result malformed");

	// surface result carries no moisture rate
	a_surf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_out |-> result.moisture_rate == 0)
		else $error("surface result has moisture rate");

	// only the final result of a grid may report a short grid
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_out |-> result.status != STAT_SHORT)
		else $error("short status on inner result");

endmodule

bind shrinking_drying_pde_rate_top sdp_checker u_sdp_checker (.*);
`default_nettype wire
